// File: rtl/hsik_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsik_pkg
// Shared widths, command codes and sequencer states of the heap sort index
// unit.
// ----------------------------------------------------------------------------
package hsik_pkg;

    localparam int KEY_W         = 32;
    localparam int OUT_IDX_W     = 8;
    localparam int MAX_ITEMS_DEF = 256;

    // input command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_CHECK,
        ST_RD_START,
        ST_RD_IDX,
        ST_RD_KEY,
        ST_OUT,
        ST_BUILD_NEXT,
        ST_EXT_NEXT,
        ST_X_RD0,
        ST_X_RDI,
        ST_X_WR0,
        ST_X_WRI,
        ST_SF_RD_AT,
        ST_SF_RD_MVK,
        ST_SF_CAP_MVK,
        ST_SF_LEVEL,
        ST_SF_LK,
        ST_SF_LCMP,
        ST_SF_RK,
        ST_SF_RCMP,
        ST_SF_DECIDE,
        ST_SF_WR2
    } sort_state_t;

endpackage

// File: rtl/hsik_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsik_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module hsik_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/hsik_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsik_cmp
// Shared signed key comparator used by every sift step.
// ----------------------------------------------------------------------------
module hsik_cmp
    import hsik_pkg::*;
(
    input  logic signed [KEY_W-1:0] a,
    input  logic signed [KEY_W-1:0] b,
    output logic                    lt
);

    // strict signed less-than, ties keep the current pick
    assign lt = (a < b);

endmodule

// File: rtl/heap_sort_index_by_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_sort_index_by_key
// Collects keys tagged by arrival order and returns them in descending key
// order after an in-place heap sort of the index list.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries cmd and key. cmd = load
//   stores key as the next arrival index and gives no result; a load
//   beyond MAX_ITEMS keys is dropped. A load after reads starts a new
//   set. cmd = read returns one word on the output channel
//   (out_valid / out_stall): arrival index, key, last_position on the
//   final entry, or empty_res when no entry is left.
//   A read of an already sorted set goes through the index memory and
//   then the key memory. The first read after loading N keys runs the
//   sort first: each sift level uses the shared comparator and the
//   single write port of the index memory. The block takes no new word
//   while a command is in progress.
//   Reset clears the set count, read pointer, sorted flag and output valid;
//   the memories are not cleared and never need to be.
//   When the receiver stalls, the result word holds in the output register;
//   a further read waits for the output slot, loads go on.
// ----------------------------------------------------------------------------
module heap_sort_index_by_key
    import hsik_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        cmd,
    input  logic signed [KEY_W-1:0]     key,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [OUT_IDX_W-1:0]        sorted_index,
    output logic signed [KEY_W-1:0]     sorted_key,
    output logic                        last_position,
    output logic                        empty_res
);

    localparam int PW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int NW = CW + 1;

    sort_state_t state_reg, state_next;

    logic [CW-1:0]    load_count_reg, load_count_next;
    logic [CW-1:0]    read_ptr_reg, read_ptr_next;
    logic             sorted_reg, sorted_next;
    logic             out_valid_reg, out_valid_next;

    logic [CW-1:0]    loop_i_reg, loop_i_next;
    logic             extract_reg, extract_next;
    logic [PW-1:0]    at_reg, at_next;
    logic [PW-1:0]    mv_idx_reg, mv_idx_next;
    logic [KEY_W-1:0] mv_key_reg, mv_key_next;
    logic [PW-1:0]    cand_idx_reg, cand_idx_next;
    logic             pick_child_reg, pick_child_next;
    logic [KEY_W-1:0] pick_key_reg, pick_key_next;
    logic [PW-1:0]    pick_idx_reg, pick_idx_next;
    logic [PW-1:0]    pick_pos_reg, pick_pos_next;
    logic [PW-1:0]    res_idx_reg, res_idx_next;
    logic [KEY_W-1:0] res_key_reg, res_key_next;
    logic             res_last_reg, res_last_next;
    logic             res_empty_reg, res_empty_next;
    logic [OUT_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [KEY_W-1:0] out_key_reg, out_key_next;
    logic             out_last_reg, out_last_next;
    logic             out_empty_reg, out_empty_next;

    // memory ports
    logic             idx_we;
    logic [PW-1:0]    idx_waddr, idx_wdata, idx_raddr, idx_rdata;
    logic             key_we;
    logic [PW-1:0]    key_waddr, key_raddr;
    logic [KEY_W-1:0] key_wdata, key_rdata;

    logic             in_acc;
    logic             out_free;
    logic             load_full;
    logic [PW-1:0]    load_addr;
    logic [CW-1:0]    sift_n;
    logic [NW-1:0]    left_pos, right_pos;
    logic             left_ok, right_ok;
    logic             set_empty;
    logic [KEY_W-1:0] cmp_b;
    logic             cmp_lt;
    logic [OUT_IDX_W+PW-1:0] res_idx_wide;
    sort_state_t      sift_done_state;

    hsik_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_ITEMS)
    ) u_index_ram (
        .clk   (clk),
        .we    (idx_we),
        .waddr (idx_waddr),
        .wdata (idx_wdata),
        .raddr (idx_raddr),
        .rdata (idx_rdata)
    );

    hsik_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_ITEMS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // shared comparator: candidate key against the moving key or current pick
    assign cmp_b = (state_reg == ST_SF_LCMP) ? mv_key_reg : pick_key_reg;

    hsik_cmp u_cmp (
        .a  (key_rdata),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

    // handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // load address and full check
    assign load_full = !sorted_reg && (load_count_reg == CW'(MAX_ITEMS));
    assign load_addr = sorted_reg ? '0 : load_count_reg[PW-1:0];

    // heap geometry of the current sift
    assign sift_n    = extract_reg ? loop_i_reg : load_count_reg;
    assign left_pos  = NW'({at_reg, 1'b1});
    assign right_pos = left_pos + NW'(1);
    assign left_ok   = (left_pos < NW'(sift_n));
    assign right_ok  = (right_pos < NW'(sift_n));
    assign set_empty = (load_count_reg == '0) || (read_ptr_reg >= load_count_reg);

    assign sift_done_state = extract_reg ? ST_EXT_NEXT : ST_BUILD_NEXT;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (cmd == CMD_READ))
                begin
                    state_next = ST_RD_CHECK;
                end
            end
            ST_RD_CHECK:
            begin
                if ((load_count_reg != '0) && !sorted_reg)
                begin
                    state_next = ST_BUILD_NEXT;
                end
                else
                begin
                    state_next = ST_RD_START;
                end
            end
            ST_RD_START:   state_next = set_empty ? ST_OUT : ST_RD_IDX;
            ST_RD_IDX:     state_next = ST_RD_KEY;
            ST_RD_KEY:     state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BUILD_NEXT: state_next = (loop_i_reg == '0) ? ST_EXT_NEXT : ST_SF_RD_AT;
            ST_EXT_NEXT:   state_next = (loop_i_reg <= CW'(1)) ? ST_RD_START : ST_X_RD0;
            ST_X_RD0:      state_next = ST_X_RDI;
            ST_X_RDI:      state_next = ST_X_WR0;
            ST_X_WR0:      state_next = ST_X_WRI;
            ST_X_WRI:      state_next = ST_SF_RD_AT;
            ST_SF_RD_AT:   state_next = ST_SF_RD_MVK;
            ST_SF_RD_MVK:  state_next = ST_SF_CAP_MVK;
            ST_SF_CAP_MVK: state_next = ST_SF_LEVEL;
            ST_SF_LEVEL:   state_next = left_ok ? ST_SF_LK : sift_done_state;
            ST_SF_LK:      state_next = ST_SF_LCMP;
            ST_SF_LCMP:    state_next = right_ok ? ST_SF_RK : ST_SF_DECIDE;
            ST_SF_RK:      state_next = ST_SF_RCMP;
            ST_SF_RCMP:    state_next = ST_SF_DECIDE;
            ST_SF_DECIDE:  state_next = pick_child_reg ? ST_SF_WR2 : sift_done_state;
            ST_SF_WR2:     state_next = ST_SF_LEVEL;
            default:       state_next = ST_IDLE;
        endcase
    end

    // memory control
    always_comb
    begin
        idx_we    = 1'b0;
        idx_waddr = '0;
        idx_wdata = '0;
        idx_raddr = '0;
        key_we    = 1'b0;
        key_waddr = load_addr;
        key_wdata = key;
        key_raddr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (cmd == CMD_LOAD) && !load_full)
                begin
                    key_we    = 1'b1;
                    idx_we    = 1'b1;
                    idx_waddr = load_addr;
                    idx_wdata = load_addr;
                end
            end
            ST_RD_START:   idx_raddr = read_ptr_reg[PW-1:0];
            ST_RD_IDX:     key_raddr = idx_rdata;
            ST_SF_RD_AT:   idx_raddr = at_reg;
            ST_SF_RD_MVK:  key_raddr = idx_rdata;
            ST_SF_LEVEL:   idx_raddr = left_pos[PW-1:0];
            ST_SF_LK:      key_raddr = idx_rdata;
            ST_SF_LCMP:    idx_raddr = right_pos[PW-1:0];
            ST_SF_RK:      key_raddr = idx_rdata;
            ST_SF_DECIDE:
            begin
                if (pick_child_reg)
                begin
                    idx_we    = 1'b1;
                    idx_waddr = at_reg;
                    idx_wdata = pick_idx_reg;
                end
            end
            ST_SF_WR2:
            begin
                idx_we    = 1'b1;
                idx_waddr = pick_pos_reg;
                idx_wdata = mv_idx_reg;
            end
            ST_X_RD0:      idx_raddr = '0;
            ST_X_RDI:      idx_raddr = loop_i_reg[PW-1:0];
            ST_X_WR0:
            begin
                idx_we    = 1'b1;
                idx_waddr = '0;
                idx_wdata = idx_rdata;
            end
            ST_X_WRI:
            begin
                idx_we    = 1'b1;
                idx_waddr = loop_i_reg[PW-1:0];
                idx_wdata = mv_idx_reg;
            end
            default:
            begin
                idx_we = 1'b0;
            end
        endcase
    end

    // datapath and bookkeeping
    always_comb
    begin
        load_count_next = load_count_reg;
        read_ptr_next   = read_ptr_reg;
        sorted_next     = sorted_reg;
        loop_i_next     = loop_i_reg;
        extract_next    = extract_reg;
        at_next         = at_reg;
        mv_idx_next     = mv_idx_reg;
        mv_key_next     = mv_key_reg;
        cand_idx_next   = cand_idx_reg;
        pick_child_next = pick_child_reg;
        pick_key_next   = pick_key_reg;
        pick_idx_next   = pick_idx_reg;
        pick_pos_next   = pick_pos_reg;
        res_idx_next    = res_idx_reg;
        res_key_next    = res_key_reg;
        res_last_next   = res_last_reg;
        res_empty_next  = res_empty_reg;
        out_idx_next    = out_idx_reg;
        out_key_next    = out_key_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        out_valid_next  = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (cmd == CMD_LOAD) && !load_full)
                begin
                    load_count_next = CW'(load_addr) + CW'(1);
                    read_ptr_next   = '0;
                    sorted_next     = 1'b0;
                end
            end
            ST_RD_CHECK:
            begin
                loop_i_next  = load_count_reg >> 1;
                extract_next = 1'b0;
            end
            ST_RD_START:
            begin
                if (set_empty)
                begin
                    res_idx_next   = '0;
                    res_key_next   = '0;
                    res_last_next  = 1'b0;
                    res_empty_next = 1'b1;
                end
            end
            ST_RD_IDX:     res_idx_next = idx_rdata;
            ST_RD_KEY:
            begin
                res_key_next   = key_rdata;
                res_last_next  = ((read_ptr_reg + CW'(1)) == load_count_reg);
                res_empty_next = 1'b0;
                read_ptr_next  = read_ptr_reg + CW'(1);
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_idx_next   = res_idx_wide[OUT_IDX_W-1:0];
                    out_key_next   = res_key_reg;
                    out_last_next  = res_last_reg;
                    out_empty_next = res_empty_reg;
                    out_valid_next = 1'b1;
                end
            end
            ST_BUILD_NEXT:
            begin
                if (loop_i_reg == '0)
                begin
                    loop_i_next  = load_count_reg;
                    extract_next = 1'b1;
                end
                else
                begin
                    loop_i_next = loop_i_reg - CW'(1);
                    at_next     = loop_i_next[PW-1:0];
                end
            end
            ST_EXT_NEXT:
            begin
                if (loop_i_reg <= CW'(1))
                begin
                    sorted_next   = 1'b1;
                    read_ptr_next = '0;
                end
                else
                begin
                    loop_i_next = loop_i_reg - CW'(1);
                end
            end
            ST_X_RDI:      mv_idx_next = idx_rdata;
            ST_X_WRI:      at_next = '0;
            ST_SF_RD_MVK:  mv_idx_next = idx_rdata;
            ST_SF_CAP_MVK: mv_key_next = key_rdata;
            ST_SF_LK:      cand_idx_next = idx_rdata;
            ST_SF_LCMP:
            begin
                if (cmp_lt)
                begin
                    pick_child_next = 1'b1;
                    pick_key_next   = key_rdata;
                    pick_idx_next   = cand_idx_reg;
                    pick_pos_next   = left_pos[PW-1:0];
                end
                else
                begin
                    pick_child_next = 1'b0;
                    pick_key_next   = mv_key_reg;
                end
            end
            ST_SF_RK:      cand_idx_next = idx_rdata;
            ST_SF_RCMP:
            begin
                if (cmp_lt)
                begin
                    pick_child_next = 1'b1;
                    pick_key_next   = key_rdata;
                    pick_idx_next   = cand_idx_reg;
                    pick_pos_next   = right_pos[PW-1:0];
                end
            end
            ST_SF_WR2:     at_next = pick_pos_reg;
            default:
            begin
                at_next = at_reg;
            end
        endcase
    end

    assign res_idx_wide = (OUT_IDX_W + PW)'(res_idx_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            load_count_reg <= '0;
            read_ptr_reg   <= '0;
            sorted_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            read_ptr_reg   <= read_ptr_next;
            sorted_reg     <= sorted_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        loop_i_reg     <= loop_i_next;
        extract_reg    <= extract_next;
        at_reg         <= at_next;
        mv_idx_reg     <= mv_idx_next;
        mv_key_reg     <= mv_key_next;
        cand_idx_reg   <= cand_idx_next;
        pick_child_reg <= pick_child_next;
        pick_key_reg   <= pick_key_next;
        pick_idx_reg   <= pick_idx_next;
        pick_pos_reg   <= pick_pos_next;
        res_idx_reg    <= res_idx_next;
        res_key_reg    <= res_key_next;
        res_last_reg   <= res_last_next;
        res_empty_reg  <= res_empty_next;
        out_idx_reg    <= out_idx_next;
        out_key_reg    <= out_key_next;
        out_last_reg   <= out_last_next;
        out_empty_reg  <= out_empty_next;
    end

    // output word
    assign out_valid     = out_valid_reg;
    assign sorted_index  = out_idx_reg;
    assign sorted_key    = out_key_reg;
    assign last_position = out_last_reg;
    assign empty_res     = out_empty_reg;

    // read pointer never runs past the set
    assert property (@(posedge clk) disable iff (!rst_n)
        read_ptr_reg <= load_count_reg)
        else $error("read pointer beyond loaded set");

    // set never grows past capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= CW'(MAX_ITEMS))
        else $error("load count beyond capacity");

    // an unsorted set has not been read yet
    assert property (@(posedge clk) disable iff (!rst_n)
        !sorted_reg |-> (read_ptr_reg == '0))
        else $error("read pointer moved on an unsorted set");

    // a sift level always starts inside the heap
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SF_LEVEL) |-> (NW'(at_reg) < NW'(sift_n)))
        else $error("sift position outside heap");

    // a swap moves the element strictly downward
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SF_WR2) |-> (pick_pos_reg > at_reg))
        else $error("sift swap not toward a child");

endmodule
